@@ hdl/ppr_pkg.sv @@
// Shared types, constants and fixed-point helpers for the point-to-plane residual block.
// No dependencies; used by every module under hdl/.
package ppr_pkg;

   // Field and internal widths
   localparam int PW       = 21;  // Q8.12 positions
   localparam int NW       = 16;  // Q1.14 normals and quaternion parts
   localparam int MW       = 20;  // Q.14 rotation matrix entries
   localparam int VW       = 32;  // position-like vectors, outputs
   localparam int DW       = 24;  // direction-like vectors
   localparam int WW       = 64;  // exact sums
   localparam int FRAC_MAT = 14;
   localparam int FRAC_OUT = 2;   // Q.14 to Q.12
   localparam int AW       = 6;   // csr byte address
   localparam int DATAW    = 64;

   typedef logic signed [PW-1:0] pos_type;
   typedef logic signed [NW-1:0] nrm_type;
   typedef logic signed [MW-1:0] ment_type;
   typedef logic signed [VW-1:0] vec_type;
   typedef logic signed [DW-1:0] dir_type;
   typedef logic signed [WW-1:0] wide_type;

   typedef pos_type  [2:0]      pvec_type;
   typedef nrm_type  [2:0]      nvec_type;
   typedef vec_type  [2:0]      vvec_type;
   typedef dir_type  [2:0]      dvec_type;
   typedef wide_type [2:0]      wvec_type;
   typedef ment_type [2:0][2:0] mat_type;

   // Pose set seen by the datapath
   typedef struct packed {
      mat_type  rp;
      mat_type  ri;
      mat_type  rl;
      pvec_type pp;
      pvec_type pi;
      pvec_type tl;
   } cfg_type;

   // Last datapath stage, handed to the output stage
   typedef struct packed {
      wide_type res;
      wvec_type ms;
      wvec_type uk;
      dvec_type n;
      dvec_type rk;
      nvec_type nw;
   } tail_type;

   // Result block codes
   localparam logic [1:0] BLK_PIVOT   = 2'd0;
   localparam logic [1:0] BLK_CURRENT = 2'd1;
   localparam logic [1:0] BLK_EXTR    = 2'd2;

   // Register indexes
   localparam logic [2:0] REG_PIVOT_POS = 3'd0;
   localparam logic [2:0] REG_PIVOT_ROT = 3'd1;
   localparam logic [2:0] REG_CUR_POS   = 3'd2;
   localparam logic [2:0] REG_CUR_ROT   = 3'd3;
   localparam logic [2:0] REG_EXT_POS   = 3'd4;
   localparam logic [2:0] REG_EXT_ROT   = 3'd5;

   localparam logic [63:0] QUAT_IDENT = 64'd16384;

   localparam wide_type V_MAX = (wide_type'(1) <<< (VW - 1)) - wide_type'(1);
   localparam wide_type V_MIN = -(wide_type'(1) <<< (VW - 1));
   localparam wide_type D_MAX = (wide_type'(1) <<< (DW - 1)) - wide_type'(1);
   localparam wide_type D_MIN = -(wide_type'(1) <<< (DW - 1));

   // Round half up, then floor
   function automatic wide_type rnd(input wide_type v, input int unsigned s);
      wide_type half;
      half = wide_type'(1) <<< (s - 1);
      return (v + half) >>> s;
   endfunction

   function automatic vec_type sat_v(input wide_type v);
      vec_type r;
      if (v > V_MAX)      r = V_MAX[VW-1:0];
      else if (v < V_MIN) r = V_MIN[VW-1:0];
      else                r = v[VW-1:0];
      return r;
   endfunction

   function automatic dir_type sat_d(input wide_type v);
      dir_type r;
      if (v > D_MAX)      r = D_MAX[DW-1:0];
      else if (v < D_MIN) r = D_MIN[DW-1:0];
      else                r = v[DW-1:0];
      return r;
   endfunction

   function automatic vvec_type sat_vvec(input wvec_type v);
      vvec_type r;
      for (int i = 0; i < 3; i++) r[i] = sat_v(v[i]);
      return r;
   endfunction

   function automatic dvec_type sat_dvec(input wvec_type v);
      dvec_type r;
      for (int i = 0; i < 3; i++) r[i] = sat_d(v[i]);
      return r;
   endfunction

   function automatic vvec_type d2v(input dvec_type v);
      vvec_type r;
      for (int i = 0; i < 3; i++) r[i] = vec_type'(v[i]);
      return r;
   endfunction

   function automatic vvec_type n2v(input nvec_type v);
      vvec_type r;
      for (int i = 0; i < 3; i++) r[i] = vec_type'(v[i]);
      return r;
   endfunction

   function automatic pvec_type pos_unpack(input logic [62:0] reg_val);
      pvec_type r;
      r[0] = reg_val[62:42];
      r[1] = reg_val[41:21];
      r[2] = reg_val[20:0];
      return r;
   endfunction

   // Quaternion (x,y,z,w; w lowest) to Q.14 matrix, no normalization
   function automatic mat_type quat_to_mat(input logic [63:0] q);
      logic signed [NW-1:0] qx, qy, qz, qw;
      logic signed [31:0]   xx, yy, zz, xy, xz, yz, wx, wy, wz;
      wide_type             one;
      wide_type             t [3][3];
      wide_type             rw;
      mat_type              r;
      qw  = q[15:0];
      qz  = q[31:16];
      qy  = q[47:32];
      qx  = q[63:48];
      xx  = qx * qx;  yy = qy * qy;  zz = qz * qz;
      xy  = qx * qy;  xz = qx * qz;  yz = qy * qz;
      wx  = qw * qx;  wy = qw * qy;  wz = qw * qz;
      one = wide_type'(1) <<< 28;
      t[0][0] = one - ((wide_type'(yy) + wide_type'(zz)) <<< 1);
      t[0][1] = (wide_type'(xy) - wide_type'(wz)) <<< 1;
      t[0][2] = (wide_type'(xz) + wide_type'(wy)) <<< 1;
      t[1][0] = (wide_type'(xy) + wide_type'(wz)) <<< 1;
      t[1][1] = one - ((wide_type'(xx) + wide_type'(zz)) <<< 1);
      t[1][2] = (wide_type'(yz) - wide_type'(wx)) <<< 1;
      t[2][0] = (wide_type'(xz) - wide_type'(wy)) <<< 1;
      t[2][1] = (wide_type'(yz) + wide_type'(wx)) <<< 1;
      t[2][2] = one - ((wide_type'(xx) + wide_type'(yy)) <<< 1);
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            rw      = rnd(t[i][j], FRAC_MAT);
            r[i][j] = rw[MW-1:0];
         end
      end
      return r;
   endfunction

   // R v or R^T v, exact sum rounded by 14 bits (no saturation here)
   function automatic wvec_type mat_vec(input mat_type r, input logic tr, input vvec_type v);
      wvec_type                  o;
      wide_type                  acc;
      ment_type                  e;
      logic signed [MW+VW-1:0]   pr;
      for (int i = 0; i < 3; i++) begin
         acc = '0;
         for (int j = 0; j < 3; j++) begin
            e   = tr ? r[j][i] : r[i][j];
            pr  = e * v[j];
            acc = acc + wide_type'(pr);
         end
         o[i] = rnd(acc, FRAC_MAT);
      end
      return o;
   endfunction

   function automatic wvec_type cross_prod(input vvec_type a, input vvec_type b);
      wvec_type c;
      c[0] = a[1] * b[2] - a[2] * b[1];
      c[1] = a[2] * b[0] - a[0] * b[2];
      c[2] = a[0] * b[1] - a[1] * b[0];
      return c;
   endfunction

endpackage

@@ hdl/ppr_csr.sv @@
// Pose registers behind the csr port; rotation matrices are built at write time.
// Depends on ppr_pkg.
module ppr_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [ppr_pkg::AW-1:0]     csr_paddr,
   input  logic [ppr_pkg::DATAW-1:0]  csr_pwdata,
   output logic [ppr_pkg::DATAW-1:0]  csr_prdata,
   output ppr_pkg::cfg_type           cfg
);

   logic [62:0]      pivot_pos_ff, cur_pos_ff, ext_pos_ff;
   logic [63:0]      pivot_rot_ff, cur_rot_ff, ext_rot_ff;
   ppr_pkg::mat_type rp_ff, ri_ff, rl_ff;
   ppr_pkg::mat_type mat_in;
   logic             wr;
   logic [2:0]       idx;

   assign wr     = csr_psel & csr_penable & csr_pwrite;
   assign idx    = csr_paddr[5:3];
   assign mat_in = ppr_pkg::quat_to_mat(csr_pwdata);

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pivot_pos_ff <= '0;
         cur_pos_ff   <= '0;
         ext_pos_ff   <= '0;
         pivot_rot_ff <= ppr_pkg::QUAT_IDENT;
         cur_rot_ff   <= ppr_pkg::QUAT_IDENT;
         ext_rot_ff   <= ppr_pkg::QUAT_IDENT;
         rp_ff        <= ppr_pkg::quat_to_mat(ppr_pkg::QUAT_IDENT);
         ri_ff        <= ppr_pkg::quat_to_mat(ppr_pkg::QUAT_IDENT);
         rl_ff        <= ppr_pkg::quat_to_mat(ppr_pkg::QUAT_IDENT);
      end else if (wr) begin
         unique case (idx)
            ppr_pkg::REG_PIVOT_POS: pivot_pos_ff <= csr_pwdata[62:0];
            ppr_pkg::REG_PIVOT_ROT: begin
               pivot_rot_ff <= csr_pwdata;
               rp_ff        <= mat_in;
            end
            ppr_pkg::REG_CUR_POS:   cur_pos_ff <= csr_pwdata[62:0];
            ppr_pkg::REG_CUR_ROT: begin
               cur_rot_ff <= csr_pwdata;
               ri_ff      <= mat_in;
            end
            ppr_pkg::REG_EXT_POS:   ext_pos_ff <= csr_pwdata[62:0];
            ppr_pkg::REG_EXT_ROT: begin
               ext_rot_ff <= csr_pwdata;
               rl_ff      <= mat_in;
            end
            default: ;
         endcase
      end
   end

   // Readback
   always_comb begin
      unique case (idx)
         ppr_pkg::REG_PIVOT_POS: csr_prdata = {1'b0, pivot_pos_ff};
         ppr_pkg::REG_PIVOT_ROT: csr_prdata = pivot_rot_ff;
         ppr_pkg::REG_CUR_POS:   csr_prdata = {1'b0, cur_pos_ff};
         ppr_pkg::REG_CUR_ROT:   csr_prdata = cur_rot_ff;
         ppr_pkg::REG_EXT_POS:   csr_prdata = {1'b0, ext_pos_ff};
         ppr_pkg::REG_EXT_ROT:   csr_prdata = ext_rot_ff;
         default:                csr_prdata = '0;
      endcase
   end

   assign cfg.rp = rp_ff;
   assign cfg.ri = ri_ff;
   assign cfg.rl = rl_ff;
   assign cfg.pp = ppr_pkg::pos_unpack(pivot_pos_ff);
   assign cfg.pi = ppr_pkg::pos_unpack(cur_pos_ff);
   assign cfg.tl = ppr_pkg::pos_unpack(ext_pos_ff);

endmodule

@@ hdl/ppr_pipe.sv @@
// Six-stage datapath: frame transforms, normal chain, cross products, residual sum.
// Depends on ppr_pkg; all stages advance together on en.
module ppr_pipe (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  ppr_pkg::pvec_type    in_p,
   input  ppr_pkg::nvec_type    in_nw,
   input  ppr_pkg::pos_type     in_b,
   input  ppr_pkg::cfg_type     cfg,
   output logic                 tail_valid,
   output ppr_pkg::tail_type    tail
);

   logic [5:0] v_ff;

   // stage 0: captured request
   ppr_pkg::pvec_type p0_ff;
   ppr_pkg::nvec_type nw0_ff;
   ppr_pkg::pos_type  b0_ff;
   // stage 1
   ppr_pkg::vvec_type u1_in, u1_ff, d1_in, d1_ff, pt;
   ppr_pkg::dvec_type m1_in, m1_ff;
   ppr_pkg::nvec_type nw1_ff;
   ppr_pkg::pos_type  b1_ff;
   // stage 2
   ppr_pkg::vvec_type v2_in, v2_ff, h2_in, h2_ff, u2_ff;
   ppr_pkg::dvec_type n2_in, n2_ff, m2_ff;
   ppr_pkg::nvec_type nw2_ff;
   ppr_pkg::pos_type  b2_ff;
   // stage 3
   ppr_pkg::vvec_type g3_in, g3_ff, h3_ff, u3_ff;
   ppr_pkg::dvec_type k3_in, k3_ff, m3_ff, n3_ff;
   ppr_pkg::nvec_type nw3_ff;
   ppr_pkg::pos_type  b3_ff;
   // stage 4
   ppr_pkg::vvec_type s4_in, s4_ff, u4_ff;
   ppr_pkg::dvec_type rk4_in, rk4_ff, m4_ff, n4_ff, k4_ff;
   ppr_pkg::nvec_type nw4_ff;
   ppr_pkg::pos_type  b4_ff;
   // stage 5
   ppr_pkg::tail_type t5_in, t5_ff;

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[4:0], in_valid};
      end
   end

   // Stage 0 capture
   always_ff @(posedge clock) begin
      if (en) begin
         p0_ff  <= in_p;
         nw0_ff <= in_nw;
         b0_ff  <= in_b;
      end
   end

   // Stage 1: point into body frame, normal through extrinsic
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pt[i]    = ppr_pkg::vec_type'(p0_ff[i]) - ppr_pkg::vec_type'(cfg.tl[i]);
         d1_in[i] = ppr_pkg::vec_type'(cfg.pi[i]) - ppr_pkg::vec_type'(cfg.pp[i]);
      end
      u1_in = ppr_pkg::sat_vvec(ppr_pkg::mat_vec(cfg.rl, 1'b1, pt));
      m1_in = ppr_pkg::sat_dvec(ppr_pkg::mat_vec(cfg.rl, 1'b1, ppr_pkg::n2v(nw0_ff)));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         u1_ff  <= u1_in;
         d1_ff  <= d1_in;
         m1_ff  <= m1_in;
         nw1_ff <= nw0_ff;
         b1_ff  <= b0_ff;
      end
   end

   // Stage 2: current rotation, pivot rotation of normal and offset
   always_comb begin
      v2_in = ppr_pkg::sat_vvec(ppr_pkg::mat_vec(cfg.ri, 1'b0, u1_ff));
      n2_in = ppr_pkg::sat_dvec(ppr_pkg::mat_vec(cfg.rp, 1'b0, ppr_pkg::d2v(m1_ff)));
      h2_in = ppr_pkg::sat_vvec(ppr_pkg::mat_vec(cfg.rp, 1'b1, d1_ff));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v2_ff  <= v2_in;
         n2_ff  <= n2_in;
         h2_ff  <= h2_in;
         u2_ff  <= u1_ff;
         m2_ff  <= m1_ff;
         nw2_ff <= nw1_ff;
         b2_ff  <= b1_ff;
      end
   end

   // Stage 3: into pivot frame, normal back through current pose
   always_comb begin
      g3_in = ppr_pkg::sat_vvec(ppr_pkg::mat_vec(cfg.rp, 1'b1, v2_ff));
      k3_in = ppr_pkg::sat_dvec(ppr_pkg::mat_vec(cfg.ri, 1'b1, ppr_pkg::d2v(n2_ff)));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         g3_ff  <= g3_in;
         k3_ff  <= k3_in;
         h3_ff  <= h2_ff;
         u3_ff  <= u2_ff;
         m3_ff  <= m2_ff;
         n3_ff  <= n2_ff;
         nw3_ff <= nw2_ff;
         b3_ff  <= b2_ff;
      end
   end

   // Stage 4: transformed point sum, normal back to lidar frame
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s4_in[i] = ppr_pkg::sat_v(ppr_pkg::wide_type'(g3_ff[i])
                                 + ppr_pkg::wide_type'(h3_ff[i]));
      end
      rk4_in = ppr_pkg::sat_dvec(ppr_pkg::mat_vec(cfg.rl, 1'b0, ppr_pkg::d2v(k3_ff)));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_ff  <= s4_in;
         rk4_ff <= rk4_in;
         u4_ff  <= u3_ff;
         m4_ff  <= m3_ff;
         n4_ff  <= n3_ff;
         k4_ff  <= k3_ff;
         nw4_ff <= nw3_ff;
         b4_ff  <= b3_ff;
      end
   end

   // Stage 5: cross products and exact residual sum
   always_comb begin
      logic signed [ppr_pkg::DW+ppr_pkg::VW-1:0] pms;
      logic signed [ppr_pkg::NW+ppr_pkg::PW-1:0] pnt;
      ppr_pkg::wide_type                          acc;
      acc = ppr_pkg::wide_type'(b4_ff) <<< ppr_pkg::FRAC_MAT;
      for (int i = 0; i < 3; i++) begin
         pms = m4_ff[i] * s4_ff[i];
         pnt = nw4_ff[i] * cfg.tl[i];
         acc = acc + ppr_pkg::wide_type'(pms) + ppr_pkg::wide_type'(pnt);
      end
      t5_in.res = acc;
      t5_in.ms  = ppr_pkg::cross_prod(ppr_pkg::d2v(m4_ff), s4_ff);
      t5_in.uk  = ppr_pkg::cross_prod(u4_ff, ppr_pkg::d2v(k4_ff));
      t5_in.n   = n4_ff;
      t5_in.rk  = rk4_ff;
      t5_in.nw  = nw4_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t5_ff <= t5_in;
      end
   end

   assign tail_valid = v_ff[5];
   assign tail       = t5_ff;

endmodule

@@ hdl/ppr_out.sv @@
// Output stage: final rounding and saturation, then three results per point in turn.
// Depends on ppr_pkg; drives the pipeline advance enable.
module ppr_out (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       tail_valid,
   input  ppr_pkg::tail_type          tail,
   output logic                       en,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [1:0]                 rsp_block_index,
   output logic                       rsp_last,
   output logic signed [31:0]         rsp_residual,
   output logic signed [31:0]         rsp_jac_trans_x,
   output logic signed [31:0]         rsp_jac_trans_y,
   output logic signed [31:0]         rsp_jac_trans_z,
   output logic signed [31:0]         rsp_jac_rot_x,
   output logic signed [31:0]         rsp_jac_rot_y,
   output logic signed [31:0]         rsp_jac_rot_z
);

   logic              valid_ff;
   logic [1:0]        blk_ff;
   ppr_pkg::vec_type  res_in, res_ff;
   ppr_pkg::vvec_type jtp_in, jtc_in, jte_in, jrp_in, jrc_in, jre_in;
   ppr_pkg::vvec_type jtp_ff, jtc_ff, jte_ff, jrp_ff, jrc_ff, jre_ff;
   ppr_pkg::vvec_type jt_sel, jr_sel;
   logic              fin;

   assign fin = valid_ff & rsp_ready & (blk_ff == ppr_pkg::BLK_EXTR);
   assign en  = ~valid_ff | fin;

   // Round the translation terms from Q.14 to Q.12 and the residual and rotation terms by 14 bits, for all three blocks
   always_comb begin
      ppr_pkg::wide_type n_w, ms_w, uk_w;
      res_in = ppr_pkg::sat_v(ppr_pkg::rnd(tail.res, ppr_pkg::FRAC_MAT));
      for (int i = 0; i < 3; i++) begin
         n_w  = ppr_pkg::wide_type'(tail.n[i]);
         ms_w = tail.ms[i];
         uk_w = tail.uk[i];
         jtp_in[i] = ppr_pkg::sat_v(ppr_pkg::rnd(-n_w, ppr_pkg::FRAC_OUT));
         jtc_in[i] = ppr_pkg::sat_v(ppr_pkg::rnd(n_w, ppr_pkg::FRAC_OUT));
         jte_in[i] = ppr_pkg::sat_v(ppr_pkg::rnd(ppr_pkg::wide_type'(tail.nw[i])
                                    - ppr_pkg::wide_type'(tail.rk[i]), ppr_pkg::FRAC_OUT));
         jrp_in[i] = ppr_pkg::sat_v(ppr_pkg::rnd(ms_w, ppr_pkg::FRAC_MAT));
         jrc_in[i] = ppr_pkg::sat_v(ppr_pkg::rnd(uk_w, ppr_pkg::FRAC_MAT));
         jre_in[i] = ppr_pkg::sat_v(ppr_pkg::rnd(-(ms_w + uk_w), ppr_pkg::FRAC_MAT));
      end
   end

   // Result registers
   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
         jtp_ff <= jtp_in;
         jtc_ff <= jtc_in;
         jte_ff <= jte_in;
         jrp_ff <= jrp_in;
         jrc_ff <= jrc_in;
         jre_ff <= jre_in;
      end
   end

   // Block sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         blk_ff   <= ppr_pkg::BLK_PIVOT;
      end else if (en) begin
         valid_ff <= tail_valid;
         blk_ff   <= ppr_pkg::BLK_PIVOT;
      end else if (rsp_ready) begin
         blk_ff   <= blk_ff + 2'd1;
      end
   end

   // Pick the block being shown
   always_comb begin
      unique case (blk_ff)
         ppr_pkg::BLK_PIVOT: begin
            jt_sel = jtp_ff;
            jr_sel = jrp_ff;
         end
         ppr_pkg::BLK_CURRENT: begin
            jt_sel = jtc_ff;
            jr_sel = jrc_ff;
         end
         ppr_pkg::BLK_EXTR: begin
            jt_sel = jte_ff;
            jr_sel = jre_ff;
         end
         default: begin
            jt_sel = '0;
            jr_sel = '0;
         end
      endcase
   end

   assign rsp_valid       = valid_ff;
   assign rsp_block_index = blk_ff;
   assign rsp_last        = (blk_ff == ppr_pkg::BLK_EXTR);
   assign rsp_residual    = res_ff;
   assign rsp_jac_trans_x = jt_sel[0];
   assign rsp_jac_trans_y = jt_sel[1];
   assign rsp_jac_trans_z = jt_sel[2];
   assign rsp_jac_rot_x   = jr_sel[0];
   assign rsp_jac_rot_y   = jr_sel[1];
   assign rsp_jac_rot_z   = jr_sel[2];

endmodule

@@ hdl/pivot_point_plane_residual.sv @@
// Top level: point-to-plane residual with pivot, current and extrinsic Jacobians.
// Depends on ppr_pkg, ppr_csr, ppr_pipe, ppr_out.
//
//   channel  | direction | handshake            | carries
//   req_     | in        | req_valid/req_ready  | point, plane normal, plane offset
//   rsp_     | out       | rsp_valid/rsp_ready  | block index, last, residual, 1x6 Jacobian
//   csr_     | in/out    | APB, pready high     | three poses, 64-bit regs at 8*index
//
// The output stage presents the pivot, current and extrinsic results of a point
// one per cycle while rsp_ready is high. The first result comes from the output
// register, after the request has passed the capture register and five datapath
// stages.
// Synchronous reset clears valid bits and sets poses to zero/identity.
// The datapath advances as a whole only when the output stage is empty or is
// handing over its last result, so a stall holds every stage in place.
module pivot_point_plane_residual (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic signed [20:0]  req_point_x,
   input  logic signed [20:0]  req_point_y,
   input  logic signed [20:0]  req_point_z,
   input  logic signed [15:0]  req_normal_x,
   input  logic signed [15:0]  req_normal_y,
   input  logic signed [15:0]  req_normal_z,
   input  logic signed [20:0]  req_plane_offset,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_block_index,
   output logic                rsp_last,
   output logic signed [31:0]  rsp_residual,
   output logic signed [31:0]  rsp_jac_trans_x,
   output logic signed [31:0]  rsp_jac_trans_y,
   output logic signed [31:0]  rsp_jac_trans_z,
   output logic signed [31:0]  rsp_jac_rot_x,
   output logic signed [31:0]  rsp_jac_rot_y,
   output logic signed [31:0]  rsp_jac_rot_z,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [5:0]          csr_paddr,
   input  logic [63:0]         csr_pwdata,
   output logic [63:0]         csr_prdata,
   output logic                csr_pready
);

   ppr_pkg::cfg_type  cfg;
   ppr_pkg::tail_type tail;
   ppr_pkg::pvec_type in_p;
   ppr_pkg::nvec_type in_nw;
   logic              tail_valid;
   logic              en;

   assign csr_pready = 1'b1;
   assign req_ready  = en;

   assign in_p[0]  = req_point_x;
   assign in_p[1]  = req_point_y;
   assign in_p[2]  = req_point_z;
   assign in_nw[0] = req_normal_x;
   assign in_nw[1] = req_normal_y;
   assign in_nw[2] = req_normal_z;

   ppr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .cfg         (cfg)
   );

   ppr_pipe u_pipe (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .in_valid   (req_valid),
      .in_p       (in_p),
      .in_nw      (in_nw),
      .in_b       (req_plane_offset),
      .cfg        (cfg),
      .tail_valid (tail_valid),
      .tail       (tail)
   );

   ppr_out u_out (
      .clock           (clock),
      .reset           (reset),
      .tail_valid      (tail_valid),
      .tail            (tail),
      .en              (en),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_block_index (rsp_block_index),
      .rsp_last        (rsp_last),
      .rsp_residual    (rsp_residual),
      .rsp_jac_trans_x (rsp_jac_trans_x),
      .rsp_jac_trans_y (rsp_jac_trans_y),
      .rsp_jac_trans_z (rsp_jac_trans_z),
      .rsp_jac_rot_x   (rsp_jac_rot_x),
      .rsp_jac_rot_y   (rsp_jac_rot_y),
      .rsp_jac_rot_z   (rsp_jac_rot_z)
   );

endmodule

@@ verif/tb_pivot_point_plane_residual.sv @@
// Testbench for pivot_point_plane_residual: random points and planes under several poses,
// with an internal fixed-point predictor checking every result. Depends on ppr_pkg and the RTL.
`timescale 1ns / 100ps

module tb_pivot_point_plane_residual;

   typedef struct {
      longint px, py, pz, nx, ny, nz, b;
   } point_req_type;

   typedef struct {
      logic [1:0]  blk;
      logic        last;
      logic [31:0] res;
      logic [31:0] jt [3];
      logic [31:0] jr [3];
   } jac_rsp_type;

   logic         clock, reset;
   logic         req_valid, req_ready;
   logic [20:0]  req_point_x, req_point_y, req_point_z, req_plane_offset;
   logic [15:0]  req_normal_x, req_normal_y, req_normal_z;
   logic         rsp_valid, rsp_ready, rsp_last;
   logic [1:0]   rsp_block_index;
   logic [31:0]  rsp_residual, rsp_jac_trans_x, rsp_jac_trans_y, rsp_jac_trans_z;
   logic [31:0]  rsp_jac_rot_x, rsp_jac_rot_y, rsp_jac_rot_z;
   logic         csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [5:0]   csr_paddr;
   logic [63:0]  csr_pwdata, csr_prdata;

   pivot_point_plane_residual dut (.*);

   // Pose shadow copy
   logic [63:0] pose_regs [6];

   point_req_type pending_reqs [$];
   jac_rsp_type   expected_jacs [$];
   int  mismatches = 0;
   int  idle_cycles;
   bit  send_gaps, recv_gaps;
   int  send_gap_left, recv_gap_left;

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // ---------------- predictor ----------------
   function automatic longint sx(longint v, int w);
      longint m;
      m = (longint'(1) << w) - 1;
      v = v & m;
      if (v[w-1]) return v - (longint'(1) << w);
      return v;
   endfunction

   function automatic longint rnd_half(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint clip(longint v, int bits);
      longint lim;
      lim = longint'(1) << (bits - 1);
      if (v >= lim) return lim - 1;
      if (v < -lim) return -lim;
      return v;
   endfunction

   function automatic void rot_matrix(logic [63:0] q, output longint r [3][3]);
      longint w, z, y, x, one;
      longint t [3][3];
      w = sx(q[15:0], 16); z = sx(q[31:16], 16);
      y = sx(q[47:32], 16); x = sx(q[63:48], 16);
      one = longint'(1) << 28;
      t[0][0] = one - 2 * (y*y + z*z); t[0][1] = 2 * (x*y - w*z); t[0][2] = 2 * (x*z + w*y);
      t[1][0] = 2 * (x*y + w*z); t[1][1] = one - 2 * (x*x + z*z); t[1][2] = 2 * (y*z - w*x);
      t[2][0] = 2 * (x*z - w*y); t[2][1] = 2 * (y*z + w*x); t[2][2] = one - 2 * (x*x + y*y);
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) r[i][j] = rnd_half(t[i][j], 14);
   endfunction

   function automatic void rotate(longint r [3][3], bit tr, longint v [3],
                                  output longint o [3], input int bits);
      longint acc;
      for (int i = 0; i < 3; i++) begin
         acc = 0;
         for (int j = 0; j < 3; j++) acc += (tr ? r[j][i] : r[i][j]) * v[j];
         o[i] = clip(rnd_half(acc, 14), bits);
      end
   endfunction

   function automatic void cross3(longint a [3], longint b [3], output longint c [3]);
      c[0] = a[1]*b[2] - a[2]*b[1];
      c[1] = a[2]*b[0] - a[0]*b[2];
      c[2] = a[0]*b[1] - a[1]*b[0];
   endfunction

   function automatic void predict_jacobians(point_req_type q);
      longint rp [3][3], ri [3][3], rl [3][3];
      longint pp [3], pc [3], tl [3], p [3], nw [3];
      longint d [3], pt [3], u [3], v [3], g [3], h [3], s [3];
      longint m [3], n [3], k [3], rk [3], ms [3], uk [3];
      longint res, jt, jr;
      jac_rsp_type e;
      rot_matrix(pose_regs[ppr_pkg::REG_PIVOT_ROT], rp);
      rot_matrix(pose_regs[ppr_pkg::REG_CUR_ROT], ri);
      rot_matrix(pose_regs[ppr_pkg::REG_EXT_ROT], rl);
      for (int i = 0; i < 3; i++) begin
         pp[i] = sx(pose_regs[ppr_pkg::REG_PIVOT_POS] >> (42 - 21*i), 21);
         pc[i] = sx(pose_regs[ppr_pkg::REG_CUR_POS] >> (42 - 21*i), 21);
         tl[i] = sx(pose_regs[ppr_pkg::REG_EXT_POS] >> (42 - 21*i), 21);
      end
      p[0] = q.px; p[1] = q.py; p[2] = q.pz;
      nw[0] = q.nx; nw[1] = q.ny; nw[2] = q.nz;
      for (int i = 0; i < 3; i++) begin
         d[i] = clip(pc[i] - pp[i], 32);
         pt[i] = clip(p[i] - tl[i], 32);
      end
      rotate(rl, 1, pt, u, 32);
      rotate(ri, 0, u, v, 32);
      rotate(rp, 1, v, g, 32);
      rotate(rp, 1, d, h, 32);
      for (int i = 0; i < 3; i++) s[i] = clip(g[i] + h[i], 32);
      rotate(rl, 1, nw, m, 24);
      rotate(rp, 0, m, n, 24);
      rotate(ri, 1, n, k, 24);
      rotate(rl, 0, k, rk, 24);
      res = q.b * 16384;
      for (int i = 0; i < 3; i++) res += m[i]*s[i] + nw[i]*tl[i];
      res = rnd_half(res, 14);
      cross3(m, s, ms);
      cross3(u, k, uk);
      for (int blk = 0; blk < 3; blk++) begin
         e.blk = blk[1:0];
         e.last = (blk == 2);
         e.res = 32'(clip(res, 32));
         for (int i = 0; i < 3; i++) begin
            if (blk == 0) begin
               jt = rnd_half(-n[i], 2); jr = rnd_half(ms[i], 14);
            end else if (blk == 1) begin
               jt = rnd_half(n[i], 2); jr = rnd_half(uk[i], 14);
            end else begin
               jt = rnd_half(nw[i] - rk[i], 2); jr = rnd_half(-(ms[i] + uk[i]), 14);
            end
            e.jt[i] = 32'(clip(jt, 32));
            e.jr[i] = 32'(clip(jr, 32));
         end
         expected_jacs.push_back(e);
      end
   endfunction

   // ---------------- request driver ----------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap_left <= 0;
      end else if (!req_valid || req_ready) begin
         if (send_gaps && send_gap_left == 0 && $urandom_range(0, 5) == 0)
            send_gap_left <= $urandom_range(1, 15);
         if (send_gap_left > 0 || pending_reqs.size() == 0) begin
            req_valid <= 1'b0;
            if (send_gap_left > 0) send_gap_left <= send_gap_left - 1;
         end else begin
            point_req_type q;
            q = pending_reqs.pop_front();
            req_valid <= 1'b1;
            req_point_x <= 21'(q.px); req_point_y <= 21'(q.py); req_point_z <= 21'(q.pz);
            req_normal_x <= 16'(q.nx); req_normal_y <= 16'(q.ny);
            req_normal_z <= 16'(q.nz);
            req_plane_offset <= 21'(q.b);
            predict_jacobians(q);
         end
      end
   end

   // ---------------- result monitor ----------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_gap_left <= 0;
         idle_cycles <= 0;
      end else begin
         if (recv_gaps && recv_gap_left == 0 && $urandom_range(0, 5) == 0)
            recv_gap_left <= $urandom_range(1, 15);
         else if (recv_gap_left > 0)
            recv_gap_left <= recv_gap_left - 1;
         rsp_ready <= !(recv_gaps && recv_gap_left > 0);

         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;

         if (rsp_valid && rsp_ready) begin
            if (expected_jacs.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result block %0d", rsp_block_index);
            end else begin
               jac_rsp_type e;
               logic [31:0] got_t [3], got_r [3];
               e = expected_jacs.pop_front();
               got_t = '{rsp_jac_trans_x, rsp_jac_trans_y, rsp_jac_trans_z};
               got_r = '{rsp_jac_rot_x, rsp_jac_rot_y, rsp_jac_rot_z};
               if (e.blk !== rsp_block_index || e.last !== rsp_last || e.res !== rsp_residual
                   || e.jt != got_t || e.jr != got_r) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("mismatch blk exp %0d got %0d last exp %0b got %0b",
                              e.blk, rsp_block_index, e.last, rsp_last);
                     $display("  res exp %h got %h", e.res, rsp_residual);
                     $display("  jt exp %h %h %h got %h %h %h", e.jt[0], e.jt[1], e.jt[2],
                              got_t[0], got_t[1], got_t[2]);
                     $display("  jr exp %h %h %h got %h %h %h", e.jr[0], e.jr[1], e.jr[2],
                              got_r[0], got_r[1], got_r[2]);
                  end
               end
            end
         end
      end
   end

   // Watchdog on stalled progress
   always @(posedge clock) begin
      if (!reset && idle_cycles > 5000) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ---------------- stimulus ----------------
   task automatic csr_write(logic [2:0] idx, logic [63:0] val);
      @(posedge clock);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 3'b000}; csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      pose_regs[idx] = (idx[0] == 1'b0) ? {1'b0, val[62:0]} : val;
   endtask

   // Wait until every pending request went in and every result came back
   task automatic drain();
      while (pending_reqs.size() != 0 || req_valid || expected_jacs.size() != 0)
         @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   function automatic logic [63:0] rand_pos(int mode);
      logic [20:0] c [3];
      for (int i = 0; i < 3; i++)
         c[i] = (mode == 0) ? 21'h100000 : (mode == 1) ? 21'h0FFFFF : 21'($urandom);
      return {1'b0, c[0], c[1], c[2]};
   endfunction

   // Near-unit quaternion, or fully random for the non-normalized case
   function automatic logic [63:0] rand_quat(bit wild);
      real a, b, c, d, nrm;
      if (wild) return {$urandom, $urandom};
      a = $urandom_range(0, 2000) - 1000.0; b = $urandom_range(0, 2000) - 1000.0;
      c = $urandom_range(0, 2000) - 1000.0; d = $urandom_range(1, 2000) - 1000.0;
      nrm = $sqrt(a*a + b*b + c*c + d*d) + 0.001;
      return {16'(int'(a/nrm*16384.0)), 16'(int'(b/nrm*16384.0)),
              16'(int'(c/nrm*16384.0)), 16'(int'(d/nrm*16384.0))};
   endfunction

   function automatic point_req_type rand_point(int mode);
      point_req_type q;
      real a, b, c, nrm;
      if (mode == 0) begin
         q.px = sx($urandom, 21); q.py = sx($urandom, 21); q.pz = sx($urandom, 21);
         q.nx = sx($urandom, 16); q.ny = sx($urandom, 16); q.nz = sx($urandom, 16);
         q.b = sx($urandom, 21);
      end else begin
         // Typical scan point with a unit normal
         q.px = $signed($urandom_range(0, 400000)) - 200000;
         q.py = $signed($urandom_range(0, 400000)) - 200000;
         q.pz = $signed($urandom_range(0, 100000)) - 50000;
         a = $urandom_range(0, 2000) - 1000.0; b = $urandom_range(0, 2000) - 1000.0;
         c = $urandom_range(1, 2000) - 1000.0;
         nrm = $sqrt(a*a + b*b + c*c) + 0.001;
         q.nx = int'(a/nrm*16384.0); q.ny = int'(b/nrm*16384.0); q.nz = int'(c/nrm*16384.0);
         q.b = $signed($urandom_range(0, 200000)) - 100000;
      end
      return q;
   endfunction

   initial begin
      point_req_type q;
      reset = 1'b1;
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      csr_paddr = '0; csr_pwdata = '0;
      send_gaps = 1'b0; recv_gaps = 1'b0;
      for (int i = 0; i < 6; i++) pose_regs[i] = i[0] ? ppr_pkg::QUAT_IDENT : 64'd0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: identity poses, field extremes
      for (int i = 0; i < 8; i++) begin
         q.px = i[0] ? 1048575 : -1048576; q.py = i[1] ? 1048575 : -1048576;
         q.pz = i[2] ? 1048575 : -1048576;
         q.nx = i[0] ? 32767 : -32768; q.ny = i[1] ? -32768 : 32767;
         q.nz = i[2] ? 32767 : -32768; q.b = i[0] ? -1048576 : 1048575;
         pending_reqs.push_back(q);
      end
      q = '{0, 0, 0, 0, 0, 16384, 0}; pending_reqs.push_back(q);
      q = '{4096, -4096, 8192, 16384, 0, 0, -4096}; pending_reqs.push_back(q);
      drain();

      // Extreme poses: positions and two rotations at their limits, non-unit quaternions
      csr_write(ppr_pkg::REG_PIVOT_POS, rand_pos(0));
      csr_write(ppr_pkg::REG_PIVOT_ROT, 64'hFFFF_FFFF_FFFF_FFFF);
      csr_write(ppr_pkg::REG_CUR_POS, rand_pos(1));
      csr_write(ppr_pkg::REG_CUR_ROT, 64'h8000_8000_8000_8000);
      csr_write(ppr_pkg::REG_EXT_POS, rand_pos(0));
      csr_write(ppr_pkg::REG_EXT_ROT, 64'h7FFF_7FFF_7FFF_7FFF);
      for (int i = 0; i < 6; i++) pending_reqs.push_back(rand_point(0));
      q = '{1048575, 1048575, 1048575, 32767, 32767, 32767, 1048575};
      pending_reqs.push_back(q);
      drain();

      // Random phases, with gaps on both sides in all but the last phase
      send_gaps = 1'b1; recv_gaps = 1'b1;
      for (int ph = 0; ph < 8; ph++) begin
         csr_write(ppr_pkg::REG_PIVOT_POS, rand_pos(2));
         csr_write(ppr_pkg::REG_PIVOT_ROT, rand_quat(ph == 3));
         csr_write(ppr_pkg::REG_CUR_POS, rand_pos(2));
         csr_write(ppr_pkg::REG_CUR_ROT, rand_quat(ph == 5));
         csr_write(ppr_pkg::REG_EXT_POS, rand_pos(2));
         csr_write(ppr_pkg::REG_EXT_ROT, rand_quat(ph == 6));
         if (ph == 7) begin
            send_gaps = 1'b0; recv_gaps = 1'b0;
         end
         for (int i = 0; i < 60; i++)
            pending_reqs.push_back(rand_point($urandom_range(0, 3) == 0 ? 0 : 1));
         drain();
      end

      if (mismatches == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule

@@ files.f @@
hdl/ppr_pkg.sv
hdl/ppr_csr.sv
hdl/ppr_pipe.sv
hdl/ppr_out.sv
hdl/pivot_point_plane_residual.sv
verif/tb_pivot_point_plane_residual.sv
